// ===== rtl/core/kvt_pkg.sv =====
// Shared types for the key/value table: request codes, port field widths
// and the result word handed from the sequencer to the output register.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int REQ_W       = 2;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_W-1:0]     value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   overflow;
    } t_result;

endpackage

// ===== rtl/core/key_value_table_top.sv =====
// Key/value table top: input handshake, key and value RAMs, scan sequencer
// and the output register. Depends on kvt_pkg, kvt_ram, kvt_seq.
`timescale 1ns / 1ps

// A request (put, lookup, remove, clear) is taken when the block is idle; it
// then scans the stored keys one slot per cycle through one comparator, fed
// by the registered read port of the key RAM, and stops early on a match.
// A put, lookup or remove scans until a match or the last slot; a clear
// skips the scan. The result sits in an output register, so a stalled
// output only holds the block once the next result is ready. Every result
// carries the entry count after the request; a put of a new key into a
// full table is dropped and flagged as overflow. No clearing pass is
// needed after reset.
module key_value_table_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [kvt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [kvt_pkg::KEY_W-1:0]     i_key,
    input  logic [kvt_pkg::VALUE_W-1:0]   i_value_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [kvt_pkg::VALUE_W-1:0]   o_value_out,
    output logic [kvt_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic                          o_overflow
);

    import kvt_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic          busy;
    logic          accept;
    logic          out_free;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          key_we, val_we;
    logic [KW-1:0] wr_key, rd_key;
    logic [VW-1:0] wr_val, rd_val;
    logic          res_valid;
    t_result       res;

    logic          r_out_valid;
    t_result       r_out;

    assign o_stall  = busy;
    assign accept   = i_valid && !busy;
    assign out_free = !r_out_valid || !i_stall;

    kvt_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_key),
        .i_raddr (rd_addr),
        .o_rdata (rd_key)
    );

    kvt_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_val),
        .i_raddr (rd_addr),
        .o_rdata (rd_val)
    );

    kvt_seq #(.ENTRIES(ENTRIES), .KW(KW), .VW(VW)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_req_type  (t_req'(i_req_type)),
        .i_key       (i_key[KW-1:0]),
        .i_value_in  (i_value_in[VW-1:0]),
        .i_rd_key    (rd_key),
        .i_rd_val    (rd_val),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_key_we    (key_we),
        .o_val_we    (val_we),
        .o_wr_key    (wr_key),
        .o_wr_val    (wr_val),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_value_out   = r_out.value_out;
    assign o_entry_count = r_out.entry_count;
    assign o_overflow    = r_out.overflow;

endmodule

// ===== rtl/core/kvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kvt_seq.sv =====
// Scan sequencer: walks the slots one per cycle through a single key
// comparator, tracks the first free slot, holds valid bits and the count.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_seq #(
    parameter int ENTRIES = 16,
    parameter int KW      = 32,
    parameter int VW      = 32,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  kvt_pkg::t_req    i_req_type,
    input  logic [KW-1:0]    i_key,
    input  logic [VW-1:0]    i_value_in,
    input  logic [KW-1:0]    i_rd_key,
    input  logic [VW-1:0]    i_rd_val,
    input  logic             i_out_free,
    output logic             o_busy,
    output logic [IW-1:0]    o_rd_addr,
    output logic [IW-1:0]    o_wr_addr,
    output logic             o_key_we,
    output logic             o_val_we,
    output logic [KW-1:0]    o_wr_key,
    output logic [VW-1:0]    o_wr_val,
    output logic             o_res_valid,
    output kvt_pkg::t_result o_res
);

    import kvt_pkg::*;

    localparam int          CW   = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val_in;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_issue_on, n_issue_on;
    logic          r_chk_on, n_chk_on;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic          r_found, n_found;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [VW-1:0] r_hit_val, n_hit_val;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0] r_count, n_count;

    logic    match;
    logic    commit;
    t_result res;

    assign match  = r_chk_on && r_valid[r_chk_idx] && (i_rd_key == r_key);
    assign commit = (r_state == S_DONE) && i_out_free;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_issue_on   = r_issue_on;
        n_chk_on     = r_chk_on;
        n_chk_idx    = r_chk_idx;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_hit_val    = r_hit_val;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_count      = r_count;
        o_key_we     = 1'b0;
        o_val_we     = 1'b0;
        res          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx        = '0;
                    n_issue_on   = 1'b1;
                    n_chk_on     = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = (i_req_type == REQ_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // issue side: address r_idx now, data comes back next cycle
                if (r_issue_on) begin
                    if (!r_valid[r_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    n_chk_on  = 1'b1;
                    n_chk_idx = r_idx;
                    if (r_idx == LAST) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_chk_on = 1'b0;
                end
                // check side
                if (match) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_chk_idx;
                    n_hit_val = i_rd_val;
                    n_state   = S_DONE;
                end else if (r_chk_on && (r_chk_idx == LAST)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    unique case (r_req)
                        REQ_PUT: begin
                            if (r_found) begin
                                o_val_we = 1'b1;
                            end else if (r_free_found) begin
                                o_key_we            = 1'b1;
                                o_val_we            = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_count             = r_count + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_found) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_count            = r_count - CW'(1);
                            end
                        end
                        REQ_CLEAR: begin
                            n_valid = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        res.hit         = r_found && (r_req != REQ_CLEAR);
        res.value_out   = (r_found && (r_req == REQ_LOOKUP)) ? VALUE_W'(r_hit_val) : '0;
        res.entry_count = COUNT_OUT_W'(n_count);
        res.overflow    = (r_req == REQ_PUT) && !r_found && !r_free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == S_IDLE)) begin
            r_req    <= i_req_type;
            r_key    <= i_key;
            r_val_in <= i_value_in;
        end
        r_idx        <= n_idx;
        r_issue_on   <= n_issue_on;
        r_chk_on     <= n_chk_on;
        r_chk_idx    <= n_chk_idx;
        r_found      <= n_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_val    <= n_hit_val;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rd_addr   = r_idx;
    assign o_wr_addr   = r_found ? r_hit_idx : r_free_idx;
    assign o_wr_key    = r_key;
    assign o_wr_val    = r_val_in;
    assign o_res_valid = commit;
    assign o_res       = res;

endmodule
